// ----- src/cst_pkg.sv -----
// Shared types and codes for the counting semaphore table unit.
// Depends on nothing; every other file of the block imports it.
package cst_pkg;

    // Request action codes.
    localparam logic [2:0] ACT_FIND  = 3'd0;
    localparam logic [2:0] ACT_OPEN  = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_UP    = 3'd3;
    localparam logic [2:0] ACT_DOWN  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_BLOCK = 2'd2;

    // The free-entry search splits the open flags into groups of this size.
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

endpackage

// ----- src/cst_ctrl.sv -----
// Request sequencer of the counting semaphore table unit.
// Depends on cst_pkg for the command struct.
module cst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output cst_pkg::t_ctrl_cmd o_cmd
);
    import cst_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state == S_EXEC);
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.execute = (r_state == S_EXEC);

`ifndef SYNTHESIS
    // An accepted request always moves on to the execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute)
        else $error("accepted request did not reach execute");

    // Execute lasts exactly one cycle.
    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> !o_busy)
        else $error("execute held longer than one cycle");

    // Capture and execute never coincide.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.execute))
        else $error("capture and execute at once");
`endif

endmodule

// ----- src/cst_dpath.sv -----
// Datapath of the counting semaphore table unit: open flags, count memory,
// free-entry search and result registers. Depends on cst_pkg.
module cst_dpath #(
    parameter int SEM_COUNT  = 128,
    parameter int COUNT_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cst_pkg::t_ctrl_cmd i_cmd,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_sem_id,
    input  logic signed [15:0] i_init_value,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [6:0]         o_found_id,
    output logic               o_wake
);
    import cst_pkg::*;

    localparam int IDX_W  = $clog2(SEM_COUNT);
    localparam int NGRP   = (SEM_COUNT + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FND_W  = NGRP_W + GRP_W;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    // Open flags and count storage.
    logic [SEM_COUNT-1:0]  r_open;
    logic [COUNT_BITS-1:0] r_mem [0:SEM_COUNT-1];

    // Captured request and read data.
    logic [2:0]            r_act;
    logic [7:0]            r_id;
    logic [15:0]           r_init;
    logic [COUNT_BITS-1:0] r_cnt;

    // First search stage, one entry per group.
    logic [NGRP-1:0]  r_grp_any;
    logic [GRP_W-1:0] r_grp_low [0:NGRP-1];

    // Result registers.
    logic       r_valid;
    logic [1:0] r_status;
    logic [6:0] r_found;
    logic       r_wake;

    // Flags padded to whole groups; padding reads as open so it is never found.
    logic [NGRP*GRP_SIZE-1:0] flags_pad;

    genvar k;
    generate
        for (k = 0; k < NGRP * GRP_SIZE; k++) begin : g_pad
            if (k < SEM_COUNT) begin : g_real
                assign flags_pad[k] = r_open[k];
            end else begin : g_fill
                assign flags_pad[k] = 1'b1;
            end
        end
    endgenerate

    logic [NGRP-1:0]  grp_any;
    logic [GRP_W-1:0] grp_low [0:NGRP-1];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = ~&flags_pad[g*GRP_SIZE +: GRP_SIZE];
            grp_low[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (!flags_pad[g*GRP_SIZE + b]) begin
                    grp_low[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_id   <= i_sem_id;
            r_init <= i_init_value;
            r_cnt  <= r_mem[i_sem_id[IDX_W-1:0]];
            r_grp_any <= grp_any;
            for (int g = 0; g < NGRP; g++) begin
                r_grp_low[g] <= grp_low[g];
            end
        end
    end

    // Execute: second search stage and the request's decision.
    logic                  hit;
    logic [NGRP_W-1:0]     gsel;
    logic [FND_W-1:0]      found_full;
    logic [31:0]           found_ext;
    logic                  valid_id;
    logic [IDX_W-1:0]      idx;
    logic                  is_open;
    logic [31:0]           cnt_ext;
    logic [31:0]           init_ext;
    logic [1:0]            st;
    logic [6:0]            fnd;
    logic                  wk;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] mem_wd;
    logic                  flag_set;
    logic                  flag_clr;

    always_comb begin
        hit  = 1'b0;
        gsel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                hit  = 1'b1;
                gsel = NGRP_W'(g);
            end
        end
        found_full = {gsel, r_grp_low[gsel]};
        found_ext  = 32'(found_full);

        valid_id = ({1'b0, r_id} < 9'(SEM_COUNT));
        idx      = r_id[IDX_W-1:0];
        is_open  = valid_id && r_open[idx];
        cnt_ext  = 32'(r_cnt);
        init_ext = {17'd0, r_init[14:0]};

        st       = ST_ERR;
        fnd      = '0;
        wk       = 1'b0;
        mem_we   = 1'b0;
        mem_wd   = r_cnt;
        flag_set = 1'b0;
        flag_clr = 1'b0;

        unique case (r_act)
            ACT_FIND: begin
                if (hit) begin
                    st  = ST_OK;
                    fnd = found_ext[6:0];
                end
            end
            ACT_OPEN: begin
                if (valid_id && !r_open[idx] && !r_init[15] && init_ext <= COUNT_MAX) begin
                    st       = ST_OK;
                    mem_we   = 1'b1;
                    mem_wd   = init_ext[COUNT_BITS-1:0];
                    flag_set = 1'b1;
                end
            end
            ACT_CLOSE: begin
                if (is_open) begin
                    st       = ST_OK;
                    flag_clr = 1'b1;
                end
            end
            ACT_UP: begin
                if (is_open && cnt_ext < COUNT_MAX) begin
                    st     = ST_OK;
                    wk     = (cnt_ext == 32'd0);
                    mem_we = 1'b1;
                    mem_wd = r_cnt + COUNT_BITS'(1);
                end
            end
            ACT_DOWN: begin
                if (is_open) begin
                    if (cnt_ext == 32'd0) begin
                        st = ST_BLOCK;
                    end else begin
                        st     = ST_OK;
                        mem_we = 1'b1;
                        mem_wd = r_cnt - COUNT_BITS'(1);
                    end
                end
            end
            default: begin
                st = ST_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && mem_we) begin
            r_mem[idx] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.execute;
            if (i_cmd.execute && flag_set) begin
                r_open[idx] <= 1'b1;
            end else if (i_cmd.execute && flag_clr) begin
                r_open[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= st;
            r_found  <= fnd;
            r_wake   <= wk;
        end
    end

    assign o_done     = r_valid;
    assign o_status   = r_status;
    assign o_found_id = r_found;
    assign o_wake     = r_wake;

`ifndef SYNTHESIS
    // Wake is only reported together with a successful up.
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_wake |-> r_status == ST_OK && r_act == ACT_UP)
        else $error("wake without successful up");

    // A nonzero found index only comes from a find.
    a_found_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_found != 7'd0 |-> r_act == ACT_FIND && r_status == ST_OK)
        else $error("found index outside a successful find");

    // A successful open leaves its entry open.
    a_open_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_act == ACT_OPEN && r_status == ST_OK |-> r_open[r_id[IDX_W-1:0]])
        else $error("open succeeded but entry is closed");

    // A successful close leaves its entry closed.
    a_close_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_act == ACT_CLOSE && r_status == ST_OK |-> !r_open[r_id[IDX_W-1:0]])
        else $error("close succeeded but entry is open");
`endif

endmodule

// ----- src/counting_semaphore_table_unit.sv -----
// Top level of the counting semaphore table unit.
// Instantiates cst_ctrl and cst_dpath; depends on cst_pkg.
//
// A bank of SEM_COUNT counting semaphores with COUNT_BITS-bit counts. A request
// is taken at a rising edge where start is high and busy is low; busy is then
// high for one cycle while the entry is updated, and the result appears on
// o_status, o_found_id and o_wake for exactly one cycle with o_done high. That
// result must be taken in that cycle: there is no way to hold it. Each request
// passes through a fetch cycle that reads the entry's count from the count memory
// and the first stage of the free-entry search, and an execute cycle that writes
// the count memory back. Busy keeps a new request out while the previous one
// executes; the next can be taken while the previous result is shown. Find
// returns the lowest closed entry without reserving it. Open, close, up and down
// on an invalid identifier or an entry in the wrong state return an error and
// change nothing; down on a zero count returns would-block; up at the maximum
// count returns an error. Reset closes every entry at once, so no clearing pass
// is needed; counts are only read while their entry is open.
module counting_semaphore_table_unit #(
    parameter int SEM_COUNT  = 128,
    parameter int COUNT_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_sem_id,
    input  logic signed [15:0] i_init_value,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [6:0]         o_found_id,
    output logic               o_wake
);
    import cst_pkg::*;

    t_ctrl_cmd cmd;

    // The controller sequences each request through fetch and execute.
    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // The datapath holds all semaphore state and forms the result.
    cst_dpath #(
        .SEM_COUNT  (SEM_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_sem_id     (i_sem_id),
        .i_init_value (i_init_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found_id   (o_found_id),
        .o_wake       (o_wake)
    );

endmodule

// ----- test/counting_semaphore_table_unit_tb.sv -----
// Testbench for counting_semaphore_table_unit: a directed pass, a full-table pass and
// random request traffic, each result checked against a behavioral mirror of the table.
// Depends on cst_pkg and the counting_semaphore_table_unit RTL.
module counting_semaphore_table_unit_tb;
    import cst_pkg::*;

    localparam int SEM_COUNT    = 128;
    localparam int COUNT_BITS   = 15;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 1650;
    // A correct run has about 2000 requests with idle gaps between them; the
    // limit lies several times above what such a run needs.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to wait after the last result, well beyond the block's latency.
    localparam int SETTLE_CYCLES = 8;

    // One result transfer as the block presents it.
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] found_id;
        logic       wake;
    } t_sem_result;

    // Every input has a known value from time zero.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         i_action = ACT_FIND;
    logic [7:0]         i_sem_id = '0;
    logic signed [15:0] i_init_value = '0;
    logic               busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic [6:0]         o_found_id;
    logic               o_wake;

    // Mirror of the semaphore table. A count is only looked at while its entry
    // is open, so the initial zeros here are never compared against the block.
    logic                  entry_open [SEM_COUNT];
    logic [COUNT_BITS-1:0] sem_count  [SEM_COUNT];

    // Results owed by the block, oldest first.
    t_sem_result pending_results[$];

    int fail_count     = 0;
    int request_count  = 0;
    int ok_seen        = 0;
    int err_seen       = 0;
    int block_seen     = 0;
    int wake_seen      = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit request_raised = 1'b0;

    counting_semaphore_table_unit #(
        .SEM_COUNT (SEM_COUNT),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_sem_id    (i_sem_id),
        .i_init_value(i_init_value),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_found_id  (o_found_id),
        .o_wake      (o_wake)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one request to the mirror table and returns the result the block owes.
    function automatic t_sem_result apply_request(input logic [2:0] act,
                                                  input logic [7:0] id,
                                                  input logic signed [15:0] val);
        t_sem_result res;
        int idx;
        res.status   = ST_ERR;
        res.found_id = '0;
        res.wake     = 1'b0;
        if (act == ACT_FIND) begin
            // Walk downward so the last hit is the lowest closed entry.
            for (idx = SEM_COUNT - 1; idx >= 0; idx--) begin
                if (!entry_open[idx]) begin
                    res.status   = ST_OK;
                    res.found_id = idx[6:0];
                end
            end
            return res;
        end
        if (int'(id) >= SEM_COUNT) begin
            return res;
        end
        case (act)
            ACT_OPEN: begin
                if (val >= 0 && int'(val) <= COUNT_MAX && !entry_open[id]) begin
                    entry_open[id] = 1'b1;
                    sem_count[id]  = val[COUNT_BITS-1:0];
                    res.status     = ST_OK;
                end
            end
            ACT_CLOSE: begin
                // The stored count is kept; the next open overwrites it.
                if (entry_open[id]) begin
                    entry_open[id] = 1'b0;
                    res.status     = ST_OK;
                end
            end
            ACT_UP: begin
                if (entry_open[id] && sem_count[id] != COUNT_MAX) begin
                    res.wake      = (sem_count[id] == 0);
                    sem_count[id] = sem_count[id] + 1'b1;
                    res.status    = ST_OK;
                end
            end
            ACT_DOWN: begin
                if (entry_open[id]) begin
                    if (sem_count[id] == 0) begin
                        res.status = ST_BLOCK;
                    end else begin
                        sem_count[id] = sem_count[id] - 1'b1;
                        res.status    = ST_OK;
                    end
                end
            end
            default: begin
                // Unused action codes only report an error.
            end
        endcase
        return res;
    endfunction

    // The block cannot hold a result back, so every cycle with o_done high is
    // one result transfer and is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_sem_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d found_id %0d wake %0d",
                       o_status, o_found_id, o_wake);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_found_id !== want.found_id) begin
                    $error("found_id: expected %0d, got %0d", want.found_id, o_found_id);
                    fail_count++;
                end
                if (o_wake !== want.wake) begin
                    $error("wake: expected %0d, got %0d", want.wake, o_wake);
                    fail_count++;
                end
                case (o_status)
                    ST_OK:    ok_seen++;
                    ST_BLOCK: block_seen++;
                    default:  err_seen++;
                endcase
                if (o_wake === 1'b1) begin
                    wake_seen++;
                end
            end
        end
    end

    // Drops start if it is up. Never called in a step where start is raised.
    task automatic lower_request();
        if (request_raised) begin
            start <= 1'b0;
            request_raised = 1'b0;
        end
    endtask

    // After each transfer the sender either carries on with its burst, keeping
    // start high, or lowers start and stays quiet for a random gap. Short gaps
    // land on both the update cycle and the result cycle of the block.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            lower_request();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // Now and then a long burst with no idle cycles at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Presents one request and holds it until the block takes it, then books
    // the expected result. Called right after a rising edge.
    task automatic send_request(input logic [2:0] act, input logic [7:0] id,
                                input logic signed [15:0] val);
        if (!request_raised) begin
            start <= 1'b1;
            request_raised = 1'b1;
        end
        i_action     <= act;
        i_sem_id     <= id;
        i_init_value <= val;
        // The transfer happens at the first edge where busy was low beforehand.
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_request(act, id, val));
        request_count++;
        pace_sender();
    endtask

    // Holds off new requests until every owed result has arrived, then lets
    // the block settle.
    task automatic wait_all_results();
        lower_request();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hand-picked requests: the boundaries of every field, every action and
    // every error path.
    task automatic test_directed_cases();
        send_request(ACT_FIND, 8'd0, 16'sd0);         // empty table: entry 0 is free
        send_request(ACT_OPEN, 8'd0, 16'sd0);
        send_request(ACT_FIND, 8'd255, -16'sd1);      // find ignores id and value
        send_request(ACT_UP, 8'd0, 16'sd0);           // zero to one wakes waiters
        send_request(ACT_UP, 8'd0, 16'sd0);
        send_request(ACT_DOWN, 8'd0, 16'sd0);
        send_request(ACT_DOWN, 8'd0, 16'sd0);
        send_request(ACT_DOWN, 8'd0, 16'sd0);         // count is zero: would block
        send_request(ACT_OPEN, 8'd127, 16'sd32767);   // largest count
        send_request(ACT_UP, 8'd127, 16'sd0);         // saturates with an error
        send_request(ACT_DOWN, 8'd127, 16'sd0);
        send_request(ACT_OPEN, 8'd0, 16'sd5);         // already open
        send_request(ACT_OPEN, 8'd5, -16'sd1);        // negative initial count
        send_request(ACT_OPEN, 8'd5, -16'sd32768);
        send_request(ACT_CLOSE, 8'd5, 16'sd0);        // closed entry
        send_request(ACT_UP, 8'd5, 16'sd0);
        send_request(ACT_DOWN, 8'd5, 16'sd0);
        send_request(ACT_OPEN, 8'd128, 16'sd1);       // identifiers past the table
        send_request(ACT_CLOSE, 8'd255, 16'sd0);
        send_request(ACT_UP, 8'd200, 16'sd0);
        send_request(ACT_DOWN, 8'd128, 16'sd0);
        send_request(3'd5, 8'd0, 16'sd0);             // unused action codes
        send_request(3'd6, 8'd0, 16'sd0);
        send_request(3'd7, 8'd127, 16'sd0);
        send_request(ACT_CLOSE, 8'd0, 16'sd0);        // count survives, entry closed
        send_request(ACT_FIND, 8'd0, 16'sd0);
        wait_all_results();
    endtask

    // Opens every entry so that find has nothing left to report, then frees
    // about half of the table again at random.
    task automatic test_table_full();
        int idx;
        for (idx = 0; idx < SEM_COUNT; idx++) begin
            send_request(ACT_OPEN, idx[7:0], 16'($urandom_range(0, 4)));
            if (idx == SEM_COUNT / 2) begin
                wait_all_results();
            end
        end
        send_request(ACT_FIND, 8'd0, 16'sd0);         // no closed entry left
        send_request(ACT_DOWN, 8'd127, 16'sd0);       // 32766 after the directed part
        send_request(ACT_UP, 8'd127, 16'sd0);
        send_request(ACT_UP, 8'd127, 16'sd0);
        for (idx = 0; idx < SEM_COUNT; idx++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_request(ACT_CLOSE, idx[7:0], 16'sd0);
            end
        end
        send_request(ACT_FIND, 8'd0, 16'sd0);
        wait_all_results();
    endtask

    // Random traffic. Most requests target a few hot entries with small counts,
    // so up, down, wake, would-block and saturation all happen often; the rest
    // spreads over the whole table, invalid identifiers and unused actions.
    task automatic test_random_traffic();
        int n;
        int roll;
        logic [2:0] act;
        logic [7:0] id;
        logic signed [15:0] val;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)        act = ACT_FIND;
            else if (roll < 22)  act = ACT_OPEN;
            else if (roll < 32)  act = ACT_CLOSE;
            else if (roll < 62)  act = ACT_UP;
            else if (roll < 92)  act = ACT_DOWN;
            else if (roll < 95)  act = 3'($urandom_range(5, 7));
            else                 act = 3'($urandom_range(0, 7));

            roll = $urandom_range(0, 99);
            if (roll < 60)       id = 8'($urandom_range(0, 7));
            else if (roll < 90)  id = 8'($urandom_range(0, SEM_COUNT - 1));
            else                 id = 8'($urandom_range(SEM_COUNT, 255));

            roll = $urandom_range(0, 99);
            if (roll < 50)       val = 16'($urandom_range(0, 3));
            else if (roll < 70)  val = 16'($urandom_range(COUNT_MAX - 3, COUNT_MAX));
            else if (roll < 85)  val = 16'($urandom_range(0, COUNT_MAX));
            else                 val = 16'($urandom());

            send_request(act, id, val);
            // Let the pipeline run dry every so often.
            if (n % 400 == 399) begin
                wait_all_results();
            end
        end
        wait_all_results();
    endtask

    initial begin
        int idx;
        for (idx = 0; idx < SEM_COUNT; idx++) begin
            entry_open[idx] = 1'b0;
            sem_count[idx]  = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_table_full();
        test_random_traffic();

        $display("summary: %0d requests, %0d success, %0d error, %0d would-block, %0d wakes",
                 request_count, ok_seen, err_seen, block_seen, wake_seen);
        $display("summary: directed cases, full-table find, random traffic with idle gaps");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
